[rtl/core/qrs_pkg.sv]
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared widths, codes and sideband types of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int COEF_W = 32;          // Q16.16 coefficient and root width
  localparam int D_W    = 66;          // discriminant width
  localparam int SQ_W   = 34;          // floor(sqrt) width
  localparam int REM_W  = SQ_W + 2;    // square-root remainder width
  localparam int NUM_W  = 35;          // -b +/- s, signed
  localparam int DEN_W  = 33;          // |2a|

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  localparam logic signed [COEF_W-1:0] ROOT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COEF_W-1:0] ROOT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0] count;
    logic       deg;
  } qrs_flag_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    qrs_flag_t                flags;
  } qrs_side_t;

  typedef struct packed {
    logic [1:0]               root_count;
    logic signed [COEF_W-1:0] root_first;
    logic signed [COEF_W-1:0] root_second;
    logic                     degenerate;
    logic                     saturated;
  } qrs_res_t;

endpackage

[rtl/core/qrs_in_if.sv]
// ----------------------------------------------------------------------------
// qrs_in_if
// Coefficient channel: valid/ready with a, b, c in signed Q16.16.
// ----------------------------------------------------------------------------
interface qrs_in_if import qrs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] coef_a;
  logic signed [COEF_W-1:0] coef_b;
  logic signed [COEF_W-1:0] coef_c;

  modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
  modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

[rtl/core/qrs_out_if.sv]
// ----------------------------------------------------------------------------
// qrs_out_if
// Root channel: valid/ready with count, two roots and status flags.
// ----------------------------------------------------------------------------
interface qrs_out_if import qrs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               root_count;
  logic signed [COEF_W-1:0] root_first;
  logic signed [COEF_W-1:0] root_second;
  logic                     degenerate;
  logic                     saturated;

  modport source (output valid, output root_count, output root_first, output root_second,
                  output degenerate, output saturated, input ready);
  modport sink   (input valid, input root_count, input root_first, input root_second,
                  input degenerate, input saturated, output ready);
endinterface

[rtl/core/qrs_sqrt.sv]
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined restoring square root, one root bit per stage, with sideband.
// ----------------------------------------------------------------------------
module qrs_sqrt import qrs_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [D_W-1:0]  in_disc,
  input  qrs_side_t       in_side,
  output logic            out_valid,
  output logic [SQ_W-1:0] out_root,
  output qrs_side_t       out_side
);

  logic             v_r    [SQ_W];
  logic [D_W-1:0]   d_r    [SQ_W];
  logic [REM_W-1:0] rem_r  [SQ_W];
  logic [SQ_W-1:0]  root_r [SQ_W];
  qrs_side_t        side_r [SQ_W];

  for (genvar k = 0; k < SQ_W; k++) begin : g_stage
    localparam int BIT = SQ_W - 1 - k;
    logic                v_in;
    logic [D_W-1:0]      d_in;
    logic [2*SQ_W-1:0]   d_pad;
    logic [REM_W-1:0]    rem_in;
    logic [SQ_W-1:0]     root_in;
    qrs_side_t           side_in;
    logic [REM_W+1:0]    rem_sh;
    logic [REM_W+1:0]    trial;
    logic [REM_W+1:0]    diff;
    logic                ge;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign d_in    = in_disc;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign d_in    = d_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
    end

    // radicand padded to an even number of bits, two per root bit
    assign d_pad  = {{(2*SQ_W-D_W){1'b0}}, d_in};
    assign rem_sh = {rem_in, d_pad[2*BIT+1 -: 2]};
    assign trial  = {2'b00, root_in, 2'b01};
    assign ge     = (rem_sh >= trial);
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_r[k]    <= d_in;
        rem_r[k]  <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        root_r[k] <= {root_in[SQ_W-2:0], ge};
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = v_r[SQ_W-1];
  assign out_root  = root_r[SQ_W-1];
  assign out_side  = side_r[SQ_W-1];

endmodule

[rtl/core/qrs_div.sv]
// ----------------------------------------------------------------------------
// qrs_div
// Two-lane pipelined restoring divider, one quotient bit per stage, with
// sign restore and clipping to the signed 32-bit root range.
// ----------------------------------------------------------------------------
module qrs_div import qrs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [NUM_W-1:0]  in_num [2],
  input  logic [DEN_W-1:0]         in_den_mag,
  input  logic                     in_den_neg,
  input  qrs_flag_t                in_flags,
  output logic                     out_valid,
  output qrs_flag_t                out_flags,
  output logic signed [COEF_W-1:0] out_root [2],
  output logic                     out_sat [2]
);

  localparam int DW = NUM_W - 1 + FRAC_BITS;   // dividend = |num| << FRAC_BITS

  logic             v_r     [DW];
  logic [DEN_W-1:0] den_r   [DW];
  qrs_flag_t        flags_r [DW];
  logic             v_in    [DW];
  logic [DEN_W-1:0] den_in  [DW];
  qrs_flag_t        flags_in[DW];

  for (genvar k = 0; k < DW; k++) begin : g_com
    if (k == 0) begin : g_first
      assign v_in[k]     = in_valid;
      assign den_in[k]   = in_den_mag;
      assign flags_in[k] = in_flags;
    end else begin : g_next
      assign v_in[k]     = v_r[k-1];
      assign den_in[k]   = den_r[k-1];
      assign flags_in[k] = flags_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k]   <= den_in[k];
        flags_r[k] <= flags_in[k];
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [NUM_W-1:0] mag;
    logic [DW-1:0]    dvd_init;
    logic             neg_init;
    logic [DW-1:0]    dvd_r [DW];
    logic [DEN_W-1:0] rem_r [DW];
    logic [DW-1:0]    quo_r [DW];
    logic             neg_r [DW];
    logic [DW-1:0]    q;
    logic             sat_pos;
    logic             sat_neg;

    assign mag      = in_num[l][NUM_W-1] ? (~in_num[l] + 1'b1) : in_num[l];
    assign dvd_init = {mag[NUM_W-2:0], {FRAC_BITS{1'b0}}};
    assign neg_init = in_num[l][NUM_W-1] ^ in_den_neg;

    for (genvar k = 0; k < DW; k++) begin : g_stage
      logic [DW-1:0]    dvd_in;
      logic [DEN_W-1:0] rem_in;
      logic [DW-1:0]    quo_in;
      logic             neg_in;
      logic [DEN_W:0]   tmp;
      logic [DEN_W:0]   diff;
      logic             ge;

      if (k == 0) begin : g_first
        assign dvd_in = dvd_init;
        assign rem_in = '0;
        assign quo_in = '0;
        assign neg_in = neg_init;
      end else begin : g_next
        assign dvd_in = dvd_r[k-1];
        assign rem_in = rem_r[k-1];
        assign quo_in = quo_r[k-1];
        assign neg_in = neg_r[k-1];
      end

      assign tmp  = {rem_in, dvd_in[DW-1-k]};
      assign ge   = (tmp >= {1'b0, den_in[k]});
      assign diff = tmp - {1'b0, den_in[k]};

      always_ff @(posedge clk) begin
        if (en) begin
          dvd_r[k] <= dvd_in;
          rem_r[k] <= ge ? diff[DEN_W-1:0] : tmp[DEN_W-1:0];
          quo_r[k] <= {quo_in[DW-2:0], ge};
          neg_r[k] <= neg_in;
        end
      end
    end

    // clip the truncated quotient to the signed 32-bit range
    assign q       = quo_r[DW-1];
    assign sat_pos = (q > {{(DW-COEF_W){1'b0}}, ROOT_MAX});
    assign sat_neg = (q > {{(DW-COEF_W){1'b0}}, ROOT_MIN});

    always_comb begin
      if (neg_r[DW-1]) begin
        out_sat[l]  = sat_neg;
        out_root[l] = sat_neg ? ROOT_MIN : (~q[COEF_W-1:0] + 1'b1);
      end else begin
        out_sat[l]  = sat_pos;
        out_root[l] = sat_pos ? ROOT_MAX : q[COEF_W-1:0];
      end
    end
  end

  assign out_valid = v_r[DW-1];
  assign out_flags = flags_r[DW-1];

endmodule

[rtl/core/quadratic_root_solver.sv]
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c in signed Q16.16, exact discriminant,
// pipelined square root and division, saturating roots.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          item
//  in_ch    in   valid/ready        coef_a, coef_b, coef_c
//  out_ch   out  valid/ready        root_count, root_first, root_second,
//                                   degenerate, saturated
//
//  One item per cycle while not stalled. Coefficients in Q16.16 pass 3
//  stages of magnitudes, products and discriminant, 34 square-root stages,
//  a numerator stage, one divider stage per dividend bit, and the output
//  register.
//  Reset (rst_n low, synchronous) clears the valid bits only.
//  Stalls freeze the whole pipeline once a skid item waits behind the
//  output register; in_ch.ready is registered.
// ----------------------------------------------------------------------------
module quadratic_root_solver import qrs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  qrs_in_if.sink     in_ch,
  qrs_out_if.source  out_ch
);

  logic en;

  // stage 1: magnitudes
  logic                     v1_r;
  logic signed [COEF_W-1:0] a1_r, b1_r;
  logic [COEF_W-1:0]        am1_r, bm1_r, cm1_r;
  logic                     same1_r;

  // stage 2: products b*b and |a*c|
  logic                     v2_r;
  logic signed [COEF_W-1:0] a2_r, b2_r;
  logic [2*COEF_W-1:0]      p2_r, m2_r;
  logic                     same2_r, deg2_r;

  // stage 3: discriminant
  logic                     v3_r;
  logic [D_W-1:0]           d3_r;
  qrs_side_t                side3_r;
  logic [D_W-1:0]           q4, p66, d_sum, d_dif, d_sel;
  logic                     ac_pos, d_neg;
  qrs_flag_t                flags3_nxt;

  // square root
  logic                     sq_v;
  logic [SQ_W-1:0]          sq_root;
  qrs_side_t                sq_side;

  // stage 4: numerators and divisor
  logic                     v4_r;
  logic signed [NUM_W-1:0]  num4_r [2];
  logic [DEN_W-1:0]         den4_r;
  logic                     dneg4_r;
  qrs_flag_t                flags4_r;
  logic signed [NUM_W-1:0]  b_ext, s_ext;
  logic [COEF_W-1:0]        am_sq;

  // divider
  logic                     dv_v;
  qrs_flag_t                dv_flags;
  logic signed [COEF_W-1:0] dv_root [2];
  logic                     dv_sat [2];

  // output register and skid
  qrs_res_t                 res;
  qrs_res_t                 out_r, out_nxt, skid_r, skid_nxt;
  logic                     out_v_r, out_v_nxt, skid_v_r, skid_v_nxt;
  logic                     take;

  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  // ---- stage 1 ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r    <= in_ch.coef_a;
      b1_r    <= in_ch.coef_b;
      am1_r   <= in_ch.coef_a[COEF_W-1] ? (~in_ch.coef_a + 1'b1) : in_ch.coef_a;
      bm1_r   <= in_ch.coef_b[COEF_W-1] ? (~in_ch.coef_b + 1'b1) : in_ch.coef_b;
      cm1_r   <= in_ch.coef_c[COEF_W-1] ? (~in_ch.coef_c + 1'b1) : in_ch.coef_c;
      same1_r <= (in_ch.coef_a[COEF_W-1] == in_ch.coef_c[COEF_W-1]);
    end
  end

  // ---- stage 2 ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a2_r    <= a1_r;
      b2_r    <= b1_r;
      p2_r    <= bm1_r * bm1_r;
      m2_r    <= am1_r * cm1_r;
      same2_r <= same1_r;
      deg2_r  <= (am1_r == '0);
    end
  end

  // ---- stage 3: D = b*b - 4ac, exact ----
  assign q4     = {m2_r, 2'b00};
  assign p66    = {2'b00, p2_r};
  assign ac_pos = (m2_r != '0) && same2_r;
  assign d_sum  = p66 + q4;
  assign d_dif  = p66 - q4;
  assign d_neg  = ac_pos && (q4 > p66);
  assign d_sel  = ac_pos ? d_dif : d_sum;

  always_comb begin
    flags3_nxt.deg = deg2_r;
    if (deg2_r || d_neg) begin
      flags3_nxt.count = CNT_NONE;
    end else if (d_sel == '0) begin
      flags3_nxt.count = CNT_ONE;
    end else begin
      flags3_nxt.count = CNT_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d3_r          <= (deg2_r || d_neg) ? '0 : d_sel;
      side3_r.a     <= a2_r;
      side3_r.b     <= b2_r;
      side3_r.flags <= flags3_nxt;
    end
  end

  qrs_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_disc   (d3_r),
    .in_side   (side3_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // ---- stage 4: -b - s, -b + s, |2a| ----
  // with a double root s is zero, so the first lane gives -b/(2a)
  assign b_ext = {{(NUM_W-COEF_W){sq_side.b[COEF_W-1]}}, sq_side.b};
  assign s_ext = {{(NUM_W-SQ_W){1'b0}}, sq_root};
  assign am_sq = sq_side.a[COEF_W-1] ? (~sq_side.a + 1'b1) : sq_side.a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num4_r[0] <= -b_ext - s_ext;
      num4_r[1] <= -b_ext + s_ext;
      den4_r    <= {am_sq, 1'b0};
      dneg4_r   <= sq_side.a[COEF_W-1];
      flags4_r  <= sq_side.flags;
    end
  end

  qrs_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (v4_r),
    .in_num     (num4_r),
    .in_den_mag (den4_r),
    .in_den_neg (dneg4_r),
    .in_flags   (flags4_r),
    .out_valid  (dv_v),
    .out_flags  (dv_flags),
    .out_root   (dv_root),
    .out_sat    (dv_sat)
  );

  // ---- result assembly ----
  always_comb begin
    res.root_count  = dv_flags.count;
    res.degenerate  = dv_flags.deg;
    res.root_first  = '0;
    res.root_second = '0;
    res.saturated   = 1'b0;
    case (dv_flags.count)
      CNT_ONE: begin
        res.root_first = dv_root[0];
        res.saturated  = dv_sat[0];
      end
      CNT_TWO: begin
        res.root_first  = dv_root[0];
        res.root_second = dv_root[1];
        res.saturated   = dv_sat[0] | dv_sat[1];
      end
      default: begin
        res.root_first = '0;
      end
    endcase
  end

  // ---- output register with skid ----
  assign take = out_v_r && out_ch.ready;

  always_comb begin
    out_nxt    = out_r;
    out_v_nxt  = out_v_r;
    skid_nxt   = skid_r;
    skid_v_nxt = skid_v_r;
    if (skid_v_r) begin
      if (take) begin
        out_nxt    = skid_r;
        out_v_nxt  = 1'b1;
        skid_v_nxt = 1'b0;
      end
    end else if (dv_v) begin
      if (!out_v_r || take) begin
        out_nxt   = res;
        out_v_nxt = 1'b1;
      end else begin
        skid_nxt   = res;
        skid_v_nxt = 1'b1;
      end
    end else if (take) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.root_count  = out_r.root_count;
  assign out_ch.root_first  = out_r.root_first;
  assign out_ch.root_second = out_r.root_second;
  assign out_ch.degenerate  = out_r.degenerate;
  assign out_ch.saturated   = out_r.saturated;

endmodule
